// ===== rtl/core/byte_stuffed_frame_encoder_macros.svh =====
// Assertion macros used by the checker of the byte-stuffed frame encoder.
`ifndef BYTE_STUFFED_FRAME_ENCODER_MACROS_SVH
`define BYTE_STUFFED_FRAME_ENCODER_MACROS_SVH

// Property checked on every clock edge outside of reset.
`define BSFE_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define BSFE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/bsfe_pkg.sv =====
// Shared types and constants of the byte-stuffed frame encoder.
`default_nettype none

package bsfe_pkg;

  localparam int BYTE_W    = 8;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FLAG_VALUE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_VALUE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_MASK     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ADDRESS_VALUE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CONTROL_SEQ_ZERO = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CONTROL_SEQ_ONE  = 3'd5;

  // Register values after reset.
  localparam logic [BYTE_W-1:0] RST_FLAG_VALUE       = 8'd126;
  localparam logic [BYTE_W-1:0] RST_ESCAPE_VALUE     = 8'd125;
  localparam logic [BYTE_W-1:0] RST_ESCAPE_MASK      = 8'd32;
  localparam logic [BYTE_W-1:0] RST_ADDRESS_VALUE    = 8'd3;
  localparam logic [BYTE_W-1:0] RST_CONTROL_SEQ_ZERO = 8'd0;
  localparam logic [BYTE_W-1:0] RST_CONTROL_SEQ_ONE  = 8'd64;

  // Job queue between the front and back ends.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [BYTE_W-1:0] flag_value;
    logic [BYTE_W-1:0] escape_value;
    logic [BYTE_W-1:0] escape_mask;
    logic [BYTE_W-1:0] address_value;
    logic [BYTE_W-1:0] control_seq_zero;
    logic [BYTE_W-1:0] control_seq_one;
  } cfg_t;

  // One classified payload byte, ready to be expanded into line bytes.
  typedef struct packed {
    logic              header;     // emit opening flag, address, control, header check
    logic [BYTE_W-1:0] ctrl;       // control byte of the header
    logic [BYTE_W-1:0] data;       // raw payload byte
    logic              data_esc;   // payload byte needs an escape
    logic              closing;    // frame ends after this byte
    logic [BYTE_W-1:0] check;      // running XOR including this byte
    logic              check_esc;  // check byte needs an escape
  } job_t;

  typedef enum logic [3:0] {
    PH_START,
    PH_FLAG,
    PH_ADDR,
    PH_CTRL,
    PH_HCHK,
    PH_DESC,
    PH_DATA,
    PH_CESC,
    PH_CHECK,
    PH_CLOSE
  } phase_t;

  function automatic logic needs_escape(input logic [BYTE_W-1:0] b, input cfg_t cfg);
    return (b == cfg.flag_value) || (b == cfg.escape_value);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bsfe_front.sv =====
// Front end: accepts payload beats, tracks the frame and running check, builds jobs.
`default_nettype none

module bsfe_front
  import bsfe_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cfg_t              cfg,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [BYTE_W-1:0] payload_byte,
  input  wire logic              first_byte,
  input  wire logic              final_byte,
  input  wire logic              sequence_bit,
  input  wire logic              queue_full,
  output logic                   push,
  output job_t                   job
);

  logic [BYTE_W-1:0] payload_parity;
  logic [BYTE_W-1:0] payload_parity_next;
  logic              inside_frame;
  logic              inside_frame_next;
  logic              accept;
  logic              keep;
  logic [BYTE_W-1:0] parity_sum;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  // A continuation byte with no open frame is dropped here.
  assign keep     = first_byte || inside_frame;
  assign push     = accept && keep;

  assign parity_sum = (first_byte ? '0 : payload_parity) ^ payload_byte;

  always_comb begin
    job.header    = first_byte;
    job.ctrl      = sequence_bit ? cfg.control_seq_one : cfg.control_seq_zero;
    job.data      = payload_byte;
    job.data_esc  = needs_escape(payload_byte, cfg);
    job.closing   = final_byte;
    job.check     = parity_sum;
    job.check_esc = needs_escape(parity_sum, cfg);
  end

  always_comb begin
    payload_parity_next = payload_parity;
    inside_frame_next   = inside_frame;
    if (push) begin
      payload_parity_next = final_byte ? '0 : parity_sum;
      inside_frame_next   = !final_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_parity <= '0;
      inside_frame   <= 1'b0;
    end else begin
      payload_parity <= payload_parity_next;
      inside_frame   <= inside_frame_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bsfe_queue.sv =====
// Short job queue that decouples the front end from the back end.
`default_nettype none

module bsfe_queue
  import bsfe_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t job_in,
  output logic      full,
  input  wire logic pop,
  output job_t      head,
  output logic      head_valid
);

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bsfe_back.sv =====
// Back end: expands jobs into registered line bytes, one per unstalled cycle.
`default_nettype none

module bsfe_back
  import bsfe_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cfg_t              cfg,
  input  wire job_t              head,
  input  wire logic              head_valid,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [BYTE_W-1:0]      line_byte,
  output logic                   run_end,
  output logic                   frame_end
);

  phase_t            state;
  phase_t            state_next;
  phase_t            cur;
  phase_t            after;
  logic              advance;
  logic [BYTE_W-1:0] byte_sel;
  logic              last_sel;

  assign advance = head_valid && (!out_valid || out_ready);

  // Phase being emitted now; a fresh job picks its own first phase.
  always_comb begin
    if (state == PH_START) begin
      if (head.header) begin
        cur = PH_FLAG;
      end else if (head.data_esc) begin
        cur = PH_DESC;
      end else begin
        cur = PH_DATA;
      end
    end else begin
      cur = state;
    end
  end

  // Next state.
  always_comb begin
    case (cur)
      PH_FLAG:  after = PH_ADDR;
      PH_ADDR:  after = PH_CTRL;
      PH_CTRL:  after = PH_HCHK;
      PH_HCHK:  after = head.data_esc ? PH_DESC : PH_DATA;
      PH_DESC:  after = PH_DATA;
      PH_DATA: begin
        if (!head.closing) begin
          after = PH_START;
        end else begin
          after = head.check_esc ? PH_CESC : PH_CHECK;
        end
      end
      PH_CESC:  after = PH_CHECK;
      PH_CHECK: after = PH_CLOSE;
      PH_CLOSE: after = PH_START;
      default:  after = PH_START;
    endcase
    state_next = advance ? after : state;
  end

  // Outputs.
  always_comb begin
    case (cur)
      PH_FLAG:  byte_sel = cfg.flag_value;
      PH_ADDR:  byte_sel = cfg.address_value;
      PH_CTRL:  byte_sel = head.ctrl;
      PH_HCHK:  byte_sel = cfg.address_value ^ head.ctrl;
      PH_DESC:  byte_sel = cfg.escape_value;
      PH_DATA:  byte_sel = head.data_esc ? (head.data ^ cfg.escape_mask) : head.data;
      PH_CESC:  byte_sel = cfg.escape_value;
      PH_CHECK: byte_sel = head.check_esc ? (head.check ^ cfg.escape_mask) : head.check;
      PH_CLOSE: byte_sel = cfg.flag_value;
      default:  byte_sel = cfg.flag_value;
    endcase
    last_sel = (after == PH_START);
    pop      = advance && last_sel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= PH_START;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      line_byte <= byte_sel;
      run_end   <= last_sel;
      frame_end <= (cur == PH_CLOSE);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/byte_stuffed_frame_encoder.sv =====
// Top level of the byte-stuffed frame encoder: configuration registers and datapath.
//
// Payload bytes enter on the s_axis channel, one byte per beat. tuser[0] marks the
// first byte of a frame (the opening flag, address, control and header check go out
// before it), tuser[1] is the sequence bit that picks the control byte, and tlast
// marks the final byte (the stuffed XOR check and the closing flag follow it).
// A byte that is neither first nor inside an open frame is dropped without output.
// Encoded line bytes leave on the m_axis channel; tlast is set on the last line byte
// caused by one input beat and tuser[0] on the closing flag of a frame.
// Each kept input beat turns into 1 to 9 line beats, two for a stuffed mid-frame
// byte. The back end emits one line byte per cycle while a job waits and m_axis is
// not stalled. A four-job queue lets the input keep accepting while the output works
// or is stalled; s_axis_tready only drops when that queue is full. A beat accepted
// while the queue and output register are free is written into a queue slot, and its
// first line byte then goes from that slot into the output register and onto m_axis.
// When the receiver holds m_axis_tready low, the current beat stays unchanged on the
// output, the queue fills, and then the input stalls.
// Synchronous reset empties the queue and the output, closes any open frame, clears
// the running check and restores the register defaults. Registers are written via
// cfg_we/cfg_index/cfg_data and must only change while the encoder is idle.
`default_nettype none

module byte_stuffed_frame_encoder
  import bsfe_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // Input stream.
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [7:0]           s_axis_tdata,   // [7:0] payload_byte
  input  wire logic                 s_axis_tlast,   // final_byte
  input  wire logic [1:0]           s_axis_tuser,   // [0] first_byte, [1] sequence_bit
  // Output stream.
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [7:0]                m_axis_tdata,   // [7:0] line_byte
  output logic                      m_axis_tlast,   // run_end
  output logic [0:0]                m_axis_tuser,   // [0] frame_end
  // Configuration write port.
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0]    cfg_data
);

  cfg_t cfg;
  job_t job_in;
  job_t head;
  logic push;
  logic pop;
  logic queue_full;
  logic head_valid;

  // Configuration registers; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.flag_value       <= RST_FLAG_VALUE;
      cfg.escape_value     <= RST_ESCAPE_VALUE;
      cfg.escape_mask      <= RST_ESCAPE_MASK;
      cfg.address_value    <= RST_ADDRESS_VALUE;
      cfg.control_seq_zero <= RST_CONTROL_SEQ_ZERO;
      cfg.control_seq_one  <= RST_CONTROL_SEQ_ONE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FLAG_VALUE:       cfg.flag_value       <= cfg_data;
        REG_ESCAPE_VALUE:     cfg.escape_value     <= cfg_data;
        REG_ESCAPE_MASK:      cfg.escape_mask      <= cfg_data;
        REG_ADDRESS_VALUE:    cfg.address_value    <= cfg_data;
        REG_CONTROL_SEQ_ZERO: cfg.control_seq_zero <= cfg_data;
        REG_CONTROL_SEQ_ONE:  cfg.control_seq_one  <= cfg_data;
        default: ;
      endcase
    end
  end

  // The front end classifies each beat and keeps the frame state and running check.
  bsfe_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .payload_byte (s_axis_tdata),
    .first_byte   (s_axis_tuser[0]),
    .final_byte   (s_axis_tlast),
    .sequence_bit (s_axis_tuser[1]),
    .queue_full   (queue_full),
    .push         (push),
    .job          (job_in)
  );

  bsfe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .job_in     (job_in),
    .full       (queue_full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  // The back end walks the header, data, stuffing, check and flag bytes of each job.
  bsfe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .line_byte  (m_axis_tdata),
    .run_end    (m_axis_tlast),
    .frame_end  (m_axis_tuser[0])
  );

endmodule

`default_nettype wire

// ===== rtl/core/bsfe_checker.sv =====
// Port-level checker of the byte-stuffed frame encoder and its bind statement.
`default_nettype none

`include "byte_stuffed_frame_encoder_macros.svh"

module bsfe_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_axis_tvalid,
  input wire logic       s_axis_tready,
  input wire logic [7:0] s_axis_tdata,
  input wire logic       s_axis_tlast,
  input wire logic [1:0] s_axis_tuser,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic       m_axis_tlast,
  input wire logic [0:0] m_axis_tuser
);

  logic        in_stall;
  logic [11:0] in_beat;
  logic        out_stall;
  logic [10:0] out_beat;
  logic        close_out;

  assign in_stall  = s_axis_tvalid && !s_axis_tready;
  assign in_beat   = {s_axis_tvalid, s_axis_tuser, s_axis_tlast, s_axis_tdata};
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_beat  = {m_axis_tvalid, m_axis_tuser, m_axis_tlast, m_axis_tdata};
  assign close_out = m_axis_tvalid && m_axis_tuser[0];

  // The closing flag is always the last byte of its input beat.
  `BSFE_ASSERT(a_close_ends_run, clk, rst, close_out |-> m_axis_tlast, "flag without tlast")

  // A stalled output beat holds its contents.
  `BSFE_ASSERT(a_out_hold, clk, rst, out_stall |=> $stable(out_beat), "stalled beat changed")

  // A waiting input beat is held by the sender until it is taken.
  `BSFE_ASSERT(a_in_hold, clk, rst, in_stall |=> $stable(in_beat), "input beat changed")

  // Reset leaves nothing on the output.
  `BSFE_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !m_axis_tvalid, "valid right after reset")

endmodule

bind byte_stuffed_frame_encoder bsfe_checker u_checker (.*);

`default_nettype wire

// ===== test/tb_byte_stuffed_frame_encoder.sv =====
// Self-checking testbench for the byte-stuffed frame encoder: directed rows, then random frames.
`default_nettype none

module tb_byte_stuffed_frame_encoder
  import bsfe_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // One payload beat as it travels on the input stream.
  typedef struct packed {
    logic [7:0] payload;
    logic       first_byte;
    logic       final_byte;
    logic       seq_bit;
  } payload_beat_t;

  // One encoded line byte as it leaves on the output stream.
  typedef struct packed {
    logic [7:0] line_byte;
    logic       run_end;
    logic       frame_end;
  } line_beat_t;

  typedef enum logic [0:0] {ROW_BEAT, ROW_REG} row_kind_t;

  // A row of the directed part. For a beat row, typed_n >= 0 means the line bytes
  // are written out by hand (first byte in typed[0]); -1 leaves it to the predictor.
  typedef struct {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [7:0]           value;
    logic                 first_byte;
    logic                 final_byte;
    logic                 seq_bit;
    int                   typed_n;
    logic [0:8][7:0]      typed;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata = '0;
  logic                 s_axis_tlast = 1'b0;
  logic [1:0]           s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [7:0]           m_axis_tdata;
  logic                 m_axis_tlast;
  logic [0:0]           m_axis_tuser;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BYTE_W-1:0]    cfg_data = '0;

  byte_stuffed_frame_encoder dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),    // [7:0] payload_byte
    .s_axis_tlast  (s_axis_tlast),    // final_byte
    .s_axis_tuser  (s_axis_tuser),    // [0] first_byte, [1] sequence_bit
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),    // [7:0] line_byte
    .m_axis_tlast  (m_axis_tlast),    // run_end
    .m_axis_tuser  (m_axis_tuser),    // [0] frame_end
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // 20 ns clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the encoder: register file plus framing state.
  cfg_t       enc_cfg;
  logic [7:0] running_check;
  logic       frame_open;

  // Line bytes the encoder still owes us, oldest first, and the bytes of the latest beat.
  line_beat_t expected_line_q[$];
  line_beat_t beat_bytes_q[$];

  // While set, neither side inserts idle cycles.
  logic steady = 1'b0;

  int fail_count    = 0;
  int framed_beats  = 0;
  int ignored_beats = 0;
  int frames_closed = 0;
  int line_checked  = 0;
  int reg_writes    = 0;

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10)
      $display("[%0t] MISMATCH: %s", $realtime, msg);
  endfunction

  function automatic void push_line(input logic [7:0] b, input logic closing);
    line_beat_t lb;
    lb.line_byte = b;
    lb.run_end   = 1'b0;
    lb.frame_end = closing;
    beat_bytes_q.push_back(lb);
  endfunction

  // A byte that collides with the flag or the escape goes out as escape + masked byte.
  function automatic void push_stuffed(input logic [7:0] b);
    if (b == enc_cfg.flag_value || b == enc_cfg.escape_value) begin
      push_line(enc_cfg.escape_value, 1'b0);
      push_line(b ^ enc_cfg.escape_mask, 1'b0);
    end else begin
      push_line(b, 1'b0);
    end
  endfunction

  // Works out the line bytes caused by one accepted payload beat and advances the
  // shadow state. A beat outside an open frame, not marked first, yields nothing.
  function automatic void encode_beat(input payload_beat_t pb);
    logic [7:0] ctrl;
    line_beat_t tail;
    beat_bytes_q.delete();
    if (!pb.first_byte && !frame_open)
      return;
    if (pb.first_byte) begin
      // Header is never stuffed; an open frame is simply abandoned here.
      ctrl = pb.seq_bit ? enc_cfg.control_seq_one : enc_cfg.control_seq_zero;
      push_line(enc_cfg.flag_value, 1'b0);
      push_line(enc_cfg.address_value, 1'b0);
      push_line(ctrl, 1'b0);
      push_line(enc_cfg.address_value ^ ctrl, 1'b0);
      running_check = '0;
      frame_open    = 1'b1;
    end
    running_check = running_check ^ pb.payload;
    push_stuffed(pb.payload);
    if (pb.final_byte) begin
      push_stuffed(running_check);
      push_line(enc_cfg.flag_value, 1'b1);
      running_check = '0;
      frame_open    = 1'b0;
    end
    tail = beat_bytes_q.pop_back();
    tail.run_end = 1'b1;
    beat_bytes_q.push_back(tail);
  endfunction

  // Offers one beat, idling at random first, and predicts it once it is taken.
  task automatic send_beat(input payload_beat_t pb);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 36) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = pb.payload;
    s_axis_tlast  = pb.final_byte;
    s_axis_tuser  = {pb.seq_bit, pb.first_byte};
    do @(posedge clk); while (!s_axis_tready);
    encode_beat(pb);
    if (beat_bytes_q.size() == 0) begin
      ignored_beats++;
    end else begin
      framed_beats++;
      if (pb.final_byte)
        frames_closed++;
    end
    foreach (beat_bytes_q[i])
      expected_line_q.push_back(beat_bytes_q[i]);
  endtask

  // Stops offering beats and waits until every owed line byte has come out, then
  // lets the pipeline drain of beats that produce nothing.
  task automatic wait_idle();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (expected_line_q.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    case (idx)
      REG_FLAG_VALUE:       enc_cfg.flag_value       = val;
      REG_ESCAPE_VALUE:     enc_cfg.escape_value     = val;
      REG_ESCAPE_MASK:      enc_cfg.escape_mask      = val;
      REG_ADDRESS_VALUE:    enc_cfg.address_value    = val;
      REG_CONTROL_SEQ_ZERO: enc_cfg.control_seq_zero = val;
      REG_CONTROL_SEQ_ONE:  enc_cfg.control_seq_one  = val;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic write_all_regs(input cfg_t c);
    wait_idle();
    write_reg(REG_FLAG_VALUE, c.flag_value);
    write_reg(REG_ESCAPE_VALUE, c.escape_value);
    write_reg(REG_ESCAPE_MASK, c.escape_mask);
    write_reg(REG_ADDRESS_VALUE, c.address_value);
    write_reg(REG_CONTROL_SEQ_ZERO, c.control_seq_zero);
    write_reg(REG_CONTROL_SEQ_ONE, c.control_seq_one);
  endtask

  // Payload bytes lean toward the flag and escape values so stuffing is exercised often.
  function automatic logic [7:0] pick_payload();
    int r;
    r = $urandom_range(99);
    if (r < 25)
      return enc_cfg.flag_value;
    else if (r < 40)
      return enc_cfg.escape_value;
    return 8'($urandom);
  endfunction

  function automatic stim_row_t beat_row(input logic [7:0] payload, input logic first,
                                         input logic last, input logic seq,
                                         input int n, input logic [0:8][7:0] bytes);
    stim_row_t r;
    r.kind       = ROW_BEAT;
    r.reg_idx    = REG_FLAG_VALUE;
    r.value      = payload;
    r.first_byte = first;
    r.final_byte = last;
    r.seq_bit    = seq;
    r.typed_n    = n;
    r.typed      = bytes;
    return r;
  endfunction

  function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [7:0] val);
    stim_row_t r;
    r = beat_row(val, 1'b0, 1'b0, 1'b0, -1, '0);
    r.kind    = ROW_REG;
    r.reg_idx = idx;
    return r;
  endfunction

  // Receiver: holds back tready in about a third of the cycles unless steady.
  always @(negedge clk)
    m_axis_tready <= steady || ($urandom_range(99) >= 36);

  // Output checker: every accepted line beat is matched against the oldest expectation.
  always @(posedge clk) begin
    line_beat_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_line_q.size() == 0) begin
        note_failure($sformatf("unexpected line byte %02h last=%b end=%b",
                               m_axis_tdata, m_axis_tlast, m_axis_tuser[0]));
      end else begin
        want = expected_line_q.pop_front();
        line_checked++;
        if (m_axis_tdata !== want.line_byte)
          note_failure($sformatf("line byte: expected %02h, got %02h",
                                 want.line_byte, m_axis_tdata));
        if (m_axis_tlast !== want.run_end)
          note_failure($sformatf("run end (tlast) with byte %02h: expected %b, got %b",
                                 want.line_byte, want.run_end, m_axis_tlast));
        if (m_axis_tuser[0] !== want.frame_end)
          note_failure($sformatf("frame end (tuser) with byte %02h: expected %b, got %b",
                                 want.line_byte, want.frame_end, m_axis_tuser[0]));
      end
    end
  end

  // Hard stop in case the encoder hangs.
  initial begin
    #4_000_000;
    $display("Timeout with %0d line bytes still owed", expected_line_q.size());
    $display("byte_stuffed_frame_encoder test failed");
    $finish;
  end

  initial begin
    stim_row_t     stim_rows[$];
    stim_row_t     row;
    payload_beat_t pb;
    cfg_t          next_cfg;
    int            phase_goal;
    int            len;
    int            r;

    enc_cfg.flag_value       = RST_FLAG_VALUE;
    enc_cfg.escape_value     = RST_ESCAPE_VALUE;
    enc_cfg.escape_mask      = RST_ESCAPE_MASK;
    enc_cfg.address_value    = RST_ADDRESS_VALUE;
    enc_cfg.control_seq_zero = RST_CONTROL_SEQ_ZERO;
    enc_cfg.control_seq_one  = RST_CONTROL_SEQ_ONE;
    running_check = '0;
    frame_open    = 1'b0;

    // Directed rows, reset register values first (flag 7E, escape 7D, mask 20,
    // address 03, control 00 / 40).
    // One-byte frame of zero: header, byte, check, closing flag.
    stim_rows.push_back(beat_row(8'h00, 1'b1, 1'b1, 1'b0, 7,
      {8'h7E, 8'h03, 8'h00, 8'h03, 8'h00, 8'h00, 8'h7E, 16'h0}));
    // First byte equal to the flag, sequence one.
    stim_rows.push_back(beat_row(8'h7E, 1'b1, 1'b0, 1'b1, 6,
      {8'h7E, 8'h03, 8'h40, 8'h43, 8'h7D, 8'h5E, 24'h0}));
    stim_rows.push_back(beat_row(8'hFF, 1'b0, 1'b0, 1'b0, 1, {8'hFF, 64'h0}));
    // Last byte equal to the escape; the sequence bit is ignored here.
    stim_rows.push_back(beat_row(8'h7D, 1'b0, 1'b1, 1'b1, 4,
      {8'h7D, 8'h5D, 8'hFC, 8'h7E, 40'h0}));
    // Byte with no open frame: dropped without output.
    stim_rows.push_back(beat_row(8'h55, 1'b0, 1'b0, 1'b0, 0, '0));
    // Worst case: one-byte frame whose byte and check both need escaping.
    stim_rows.push_back(beat_row(8'h7D, 1'b1, 1'b1, 1'b0, 9,
      {8'h7E, 8'h03, 8'h00, 8'h03, 8'h7D, 8'h5D, 8'h7D, 8'h5D, 8'h7E}));
    // Two bytes whose check equals the flag.
    stim_rows.push_back(beat_row(8'h12, 1'b1, 1'b0, 1'b1, -1, '0));
    stim_rows.push_back(beat_row(8'h6C, 1'b0, 1'b1, 1'b0, -1, '0));
    // A first byte inside an open frame abandons it and restarts the check.
    stim_rows.push_back(beat_row(8'hA5, 1'b1, 1'b0, 1'b0, -1, '0));
    stim_rows.push_back(beat_row(8'h3C, 1'b1, 1'b0, 1'b1, -1, '0));
    stim_rows.push_back(beat_row(8'hC3, 1'b0, 1'b1, 1'b0, -1, '0));
    // Extreme registers, with flag and escape both zero.
    stim_rows.push_back(reg_row(REG_FLAG_VALUE, 8'h00));
    stim_rows.push_back(reg_row(REG_ESCAPE_VALUE, 8'h00));
    stim_rows.push_back(reg_row(REG_ESCAPE_MASK, 8'hFF));
    stim_rows.push_back(reg_row(REG_ADDRESS_VALUE, 8'hFF));
    stim_rows.push_back(reg_row(REG_CONTROL_SEQ_ZERO, 8'hFF));
    stim_rows.push_back(reg_row(REG_CONTROL_SEQ_ONE, 8'h00));
    stim_rows.push_back(beat_row(8'h00, 1'b1, 1'b0, 1'b1, -1, '0));
    stim_rows.push_back(beat_row(8'hFF, 1'b0, 1'b0, 1'b0, -1, '0));
    stim_rows.push_back(beat_row(8'h00, 1'b0, 1'b1, 1'b0, -1, '0));
    stim_rows.push_back(beat_row(8'h80, 1'b0, 1'b0, 1'b1, -1, '0));
    stim_rows.push_back(beat_row(8'hFF, 1'b1, 1'b1, 1'b0, -1, '0));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (stim_rows[i]) begin
      row = stim_rows[i];
      if (row.kind == ROW_REG) begin
        wait_idle();
        write_reg(row.reg_idx, row.value);
      end else begin
        pb.payload    = row.value;
        pb.first_byte = row.first_byte;
        pb.final_byte = row.final_byte;
        pb.seq_bit    = row.seq_bit;
        send_beat(pb);
        // Hand-written rows also guard the predictor itself.
        if (row.typed_n >= 0) begin
          if (beat_bytes_q.size() != row.typed_n)
            note_failure($sformatf("directed row %0d: %0d line bytes predicted, %0d written",
                                   i, beat_bytes_q.size(), row.typed_n));
          else
            foreach (beat_bytes_q[k])
              if (beat_bytes_q[k].line_byte !== row.typed[k])
                note_failure($sformatf("directed row %0d byte %0d: written %02h, predicted %02h",
                                       i, k, row.typed[k], beat_bytes_q[k].line_byte));
        end
      end
    end

    // Random part: five register settings, about 25 framed beats each.
    // Phase 0 restores the defaults, phase 1 sets every register to all ones,
    // phase 2 makes flag and escape equal, phases 3 and 4 are fully random and
    // phase 3 runs without any idle cycles.
    for (int phase = 0; phase < 5; phase++) begin
      next_cfg.flag_value       = 8'($urandom);
      next_cfg.escape_value     = 8'($urandom);
      next_cfg.escape_mask      = 8'($urandom);
      next_cfg.address_value    = 8'($urandom);
      next_cfg.control_seq_zero = 8'($urandom);
      next_cfg.control_seq_one  = 8'($urandom);
      case (phase)
        0: begin
          next_cfg.flag_value       = RST_FLAG_VALUE;
          next_cfg.escape_value     = RST_ESCAPE_VALUE;
          next_cfg.escape_mask      = RST_ESCAPE_MASK;
          next_cfg.address_value    = RST_ADDRESS_VALUE;
          next_cfg.control_seq_zero = RST_CONTROL_SEQ_ZERO;
          next_cfg.control_seq_one  = RST_CONTROL_SEQ_ONE;
        end
        1: next_cfg = '1;
        2: next_cfg.escape_value = next_cfg.flag_value;
        default: ;
      endcase
      write_all_regs(next_cfg);
      steady = (phase == 3);
      phase_goal = framed_beats + 25;

      while (framed_beats < phase_goal) begin
        // In phase 2, mid-run, starve the encoder until it has drained completely.
        if (phase == 2 && framed_beats >= phase_goal - 15 && framed_beats < phase_goal - 12)
          wait_idle();
        r = $urandom_range(99);
        if (r < 8 && !frame_open) begin
          // Stray byte between frames.
          pb.payload    = 8'($urandom);
          pb.first_byte = 1'b0;
          pb.final_byte = 1'($urandom);
          pb.seq_bit    = 1'($urandom);
          send_beat(pb);
        end else begin
          len = ($urandom_range(9) == 0) ? $urandom_range(12, 5) : $urandom_range(4, 1);
          for (int k = 0; k < len; k++) begin
            pb.payload    = pick_payload();
            pb.first_byte = (k == 0);
            // About one frame in eight is left open and cut off by the next one.
            pb.final_byte = (k == len - 1) && (r >= 20);
            pb.seq_bit    = 1'($urandom);
            send_beat(pb);
          end
        end
      end
      steady = 1'b0;
    end

    // Close any frame left open, then drain.
    if (frame_open) begin
      pb.payload    = pick_payload();
      pb.first_byte = 1'b0;
      pb.final_byte = 1'b1;
      pb.seq_bit    = 1'b0;
      send_beat(pb);
    end
    wait_idle();

    if (expected_line_q.size() != 0)
      note_failure($sformatf("%0d line bytes never arrived", expected_line_q.size()));
    if (fail_count > 10)
      $display("%0d further mismatches were counted but not shown", fail_count - 10);

    $display("Run covered %0d framed payload beats and %0d stray beats, %0d closed frames,",
             framed_beats, ignored_beats, frames_closed);
    $display("  %0d line bytes checked, %0d register writes over six settings.",
             line_checked, reg_writes);
    if (fail_count == 0) begin
      $display("byte_stuffed_frame_encoder test passed");
    end else begin
      $display("byte_stuffed_frame_encoder test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
